// File: src/prp_pkg.sv
// Package for the partial random permutation unit.
// Holds the shared field widths, register indexes, queue item type and back-end states.
// No dependencies.
`default_nettype none

package prp_pkg;

  localparam int WORD_W      = 31;
  localparam int VAL_W       = 6;
  localparam int POS_W       = 5;
  localparam int CFG_W       = 6;
  localparam int CIDX_W      = 1;
  localparam int MAX_EMIT    = 32;
  localparam int DIV_STEPS   = 31;
  localparam int DCNT_W      = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [CIDX_W-1:0] REG_SEQ_LENGTH = 1'b0;
  localparam logic [CIDX_W-1:0] REG_POOL_SIZE  = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              err;
  } prp_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] seq_length;
    logic [CFG_W-1:0] pool_size;
    logic             restore;
  } prp_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ_PICK,
    ST_WRITE_STEP,
    ST_WRITE_PICK,
    ST_EMIT_READ,
    ST_EMIT_OUT
  } prp_state_t;

endpackage

`default_nettype wire

// File: src/prp_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on prp_pkg for the queued item type.
`default_nettype none

module prp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire prp_pkg::prp_item_t push_item,
  input  wire logic              pop,
  output prp_pkg::prp_item_t     head,
  output logic                   empty,
  output logic                   full
);
  import prp_pkg::*;

  prp_item_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QPTR_W:0]      count;
  logic                 do_push;
  logic                 do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/prp_front.sv
// Front end: configuration registers, request acceptance and validity classification.
// Depends on prp_pkg; feeds prp_queue and passes configuration to prp_back.
`default_nettype none

module prp_front #(
  parameter int TABLE_SIZE = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [prp_pkg::WORD_W-1:0]  rand_word,
  input  wire logic                        wr_en,
  input  wire logic [prp_pkg::CIDX_W-1:0]  wr_index,
  input  wire logic [prp_pkg::CFG_W-1:0]   wr_data,
  input  wire logic                        q_full,
  output logic                             busy,
  output logic                             push,
  output prp_pkg::prp_item_t               push_item,
  output prp_pkg::prp_cfg_t                cfg
);
  import prp_pkg::*;

  logic [CFG_W-1:0] seq_length;
  logic [CFG_W-1:0] pool_size;
  logic             cfg_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length <= CFG_W'(4);
      pool_size  <= CFG_W'(8);
    end else if (wr_en) begin
      case (wr_index)
        REG_SEQ_LENGTH: seq_length <= wr_data;
        REG_POOL_SIZE:  pool_size  <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_ok = (seq_length != '0) && (pool_size != '0) && (seq_length <= pool_size) &&
             ({1'b0, pool_size} <= (CFG_W+1)'(TABLE_SIZE)) &&
             ({1'b0, seq_length} <= (CFG_W+1)'(MAX_EMIT));
  end

  assign busy           = q_full;
  assign push           = start && !q_full;
  assign push_item.word = rand_word;
  assign push_item.err  = !cfg_ok;

  assign cfg.seq_length = seq_length;
  assign cfg.pool_size  = pool_size;
  assign cfg.restore    = wr_en && ((wr_index == REG_SEQ_LENGTH) || (wr_index == REG_POOL_SIZE));

endmodule

`default_nettype wire

// File: src/prp_mod.sv
// Iterative remainder unit: one restoring step per cycle over the 31-bit random word.
// Depends on prp_pkg for widths; used by prp_back.
`default_nettype none

module prp_mod (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire logic [prp_pkg::WORD_W-1:0]  dividend,
  input  wire logic [prp_pkg::CFG_W-1:0]   divisor,
  output logic                             done,
  output logic [prp_pkg::CFG_W-1:0]        rem
);
  import prp_pkg::*;

  logic              running;
  logic [DCNT_W-1:0] cnt;
  logic [WORD_W-1:0] dvd;
  logic [CFG_W-1:0]  dsr;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    trial_sub;

  always_comb begin
    trial     = {rem, dvd[WORD_W-1]};
    trial_sub = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[WORD_W-2:0], 1'b0};
      rem <= (trial >= {1'b0, dsr}) ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/prp_back.sv
// Back end: shuffle sequencer, permutation table memory with valid bits, result output.
// Depends on prp_pkg and instantiates prp_mod; takes requests from prp_queue.
`default_nettype none

module prp_back #(
  parameter int TABLE_SIZE = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire prp_pkg::prp_cfg_t          cfg,
  input  wire prp_pkg::prp_item_t         head,
  input  wire logic                       q_empty,
  output logic                            pop,
  output logic                            done,
  output logic [prp_pkg::VAL_W-1:0]       value,
  output logic [prp_pkg::POS_W-1:0]       position,
  output logic                            last,
  output logic                            error
);
  import prp_pkg::*;

  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  prp_state_t        state;
  prp_state_t        state_next;
  logic [IDX_W-1:0]  step;
  logic [IDX_W-1:0]  pick;
  logic [IDX_W-1:0]  k;
  logic [VAL_W-1:0]  hold;
  logic [TABLE_SIZE-1:0] valid;

  logic [VAL_W-1:0]  mem [TABLE_SIZE];
  logic [VAL_W-1:0]  rd_data;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_addr_q;
  logic [VAL_W-1:0]  eff_rd;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic              div_load;
  logic              err_out;
  logic              val_out;

  logic              mod_done;
  logic [CFG_W-1:0]  mod_rem;
  logic [CFG_W-1:0]  span;
  logic              last_step;
  logic              last_k;

  assign span      = cfg.pool_size - CFG_W'(step);
  assign last_step = ((CFG_W+1)'(step) + 1'b1) == {1'b0, cfg.pool_size};
  assign last_k    = ((CFG_W+1)'(k) + 1'b1) == {1'b0, cfg.seq_length};
  assign eff_rd    = rd_valid ? rd_data : VAL_W'(rd_addr_q) + 1'b1;

  prp_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend (head.word),
    .divisor  (span),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_valid  <= valid[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty && !head.err) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (mod_done) begin
          state_next = ST_READ_PICK;
        end
      end
      ST_READ_PICK:  state_next = ST_WRITE_STEP;
      ST_WRITE_STEP: state_next = ST_WRITE_PICK;
      ST_WRITE_PICK: state_next = last_step ? ST_EMIT_READ : ST_IDLE;
      ST_EMIT_READ:  state_next = ST_EMIT_OUT;
      ST_EMIT_OUT:   state_next = last_k ? ST_IDLE : ST_EMIT_READ;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    div_load = 1'b0;
    err_out  = 1'b0;
    val_out  = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = step;
    wr_en    = 1'b0;
    wr_addr  = step;
    wr_data  = eff_rd;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          err_out  = head.err;
          div_load = !head.err;
        end
      end
      ST_DIVIDE: begin
        rd_en = mod_done;
      end
      ST_READ_PICK: begin
        rd_en   = 1'b1;
        rd_addr = pick;
      end
      ST_WRITE_STEP: begin
        wr_en = 1'b1;
      end
      ST_WRITE_PICK: begin
        wr_en   = 1'b1;
        wr_addr = pick;
        wr_data = hold;
      end
      ST_EMIT_READ: begin
        rd_en   = 1'b1;
        rd_addr = k;
      end
      ST_EMIT_OUT: begin
        val_out = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE && mod_done) begin
      pick <= IDX_W'((CFG_W+1)'(step) + (CFG_W+1)'(mod_rem));
    end
    if (state == ST_READ_PICK) begin
      hold <= eff_rd;
    end
    if (err_out || val_out) begin
      value    <= err_out ? '0 : eff_rd;
      position <= err_out ? '0 : POS_W'((CFG_W+1)'(k));
      last     <= err_out || last_k;
      error    <= err_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      k     <= '0;
      valid <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= err_out || val_out;
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (state == ST_WRITE_PICK) begin
        k <= '0;
        if (!last_step) begin
          step <= step + 1'b1;
        end
      end
      if (state == ST_EMIT_OUT) begin
        k <= k + 1'b1;
        if (last_k) begin
          valid <= '0;
          step  <= '0;
        end
      end
      if (cfg.restore) begin
        valid <= '0;
        step  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/partial_random_permutation_unit.sv
// Top level of the partial random permutation unit (Fisher-Yates shuffle with modulo bias).
// Depends on prp_pkg and instantiates prp_front, prp_queue and prp_back.
//
// Each request on start/rand_word performs one shuffle step; the step that completes
// pool_size steps is followed by seq_length results, each read from the table before it
// is output, and the table then returns to identity. A step takes the request from the
// queue, runs the bit-serial remainder unit (31 shift steps and a done strobe), then reads
// the table and swaps the two entries. An invalid configuration turns each request into
// one error result, registered in the cycle after it leaves the queue. Results are
// marked by done for exactly one cycle and cannot be stalled; busy is high while the
// two-entry request queue is full. Configuration writes restore the table and step count.
`default_nettype none

module partial_random_permutation_unit #(
  parameter int TABLE_SIZE = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [prp_pkg::WORD_W-1:0]  rand_word,
  input  wire logic                        wr_en,
  input  wire logic [prp_pkg::CIDX_W-1:0]  wr_index,
  input  wire logic [prp_pkg::CFG_W-1:0]   wr_data,
  output logic                             done,
  output logic [prp_pkg::VAL_W-1:0]        value,
  output logic [prp_pkg::POS_W-1:0]        position,
  output logic                             last,
  output logic                             error
);
  import prp_pkg::*;

  prp_item_t push_item;
  prp_item_t head;
  prp_cfg_t  cfg;
  logic      push;
  logic      pop;
  logic      q_empty;
  logic      q_full;

  prp_front #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .rand_word (rand_word),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  prp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  prp_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (pop),
    .done     (done),
    .value    (value),
    .position (position),
    .last     (last),
    .error    (error)
  );

endmodule

`default_nettype wire

// File: verif/tb_partial_random_permutation_unit.sv
// Testbench for partial_random_permutation_unit: drives shuffle steps and register writes,
// predicts every emitted draw and error result, and checks each one as it comes out.
// Depends on prp_pkg and the partial_random_permutation_unit RTL.
module tb_partial_random_permutation_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import prp_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam int SETTLE_CYCLES = 160;
  localparam int RANDOM_ITEMS = 210;
  localparam int IDLE_PCT = 37;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
    logic             last;
    logic             error;
  } draw_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [WORD_W-1:0] rand_word = '0;
  logic wr_en = 1'b0;
  logic [CIDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0] wr_data = '0;
  logic busy;
  logic done;
  logic [VAL_W-1:0] value;
  logic [POS_W-1:0] position;
  logic last;
  logic error;

  int unsigned seq_len_cfg = 4;
  int unsigned pool_cfg = 8;
  int unsigned shuffle_pos = 0;
  logic [VAL_W-1:0] perm [TABLE_DEPTH];
  draw_t pending_draws[$];
  int draw_mismatches = 0;
  bit idle_enable = 1'b1;
  int items_sent = 0;

  partial_random_permutation_unit #(
    .TABLE_SIZE(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .rand_word(rand_word),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .done(done),
    .value(value),
    .position(position),
    .last(last),
    .error(error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_perm();
    for (int k = 0; k < TABLE_DEPTH; k++) perm[k] = VAL_W'(k + 1);
    shuffle_pos = 0;
  endfunction

  function automatic bit config_ok();
    return seq_len_cfg >= 1 && pool_cfg >= 1 && seq_len_cfg <= pool_cfg &&
           pool_cfg <= TABLE_DEPTH && seq_len_cfg <= MAX_EMIT;
  endfunction

  // One Fisher-Yates step (or error result); completing the pool queues the whole draw.
  function automatic void shuffle_step(input logic [WORD_W-1:0] w);
    int unsigned span;
    int unsigned pick;
    logic [VAL_W-1:0] held;
    draw_t d;
    if (!config_ok() || shuffle_pos >= pool_cfg) begin
      d.value = '0;
      d.position = '0;
      d.last = 1'b1;
      d.error = 1'b1;
      pending_draws.insert(pending_draws.size(), d);
      return;
    end
    span = pool_cfg - shuffle_pos;
    pick = shuffle_pos + (32'(w) % span);
    held = perm[shuffle_pos];
    perm[shuffle_pos] = perm[pick];
    perm[pick] = held;
    shuffle_pos++;
    if (shuffle_pos == pool_cfg) begin
      for (int k = 0; k < seq_len_cfg; k++) begin
        d.value = perm[k];
        d.position = POS_W'(k);
        d.last = (k + 1 == seq_len_cfg);
        d.error = 1'b0;
        pending_draws.insert(pending_draws.size(), d);
      end
      reset_perm();
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    draw_mismatches++;
    if (draw_mismatches <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : check_draws
    draw_t seen;
    draw_t want;
    if (!rst && done) begin
      seen.value = value;
      seen.position = position;
      seen.last = last;
      seen.error = error;
      if (pending_draws.size() == 0) begin
        note_mismatch($sformatf("unexpected result: value=%0d position=%0d last=%0b error=%0b",
                                seen.value, seen.position, seen.last, seen.error));
      end else begin
        want = pending_draws.pop_front();
        if (seen.value !== want.value || seen.position !== want.position ||
            seen.last !== want.last || seen.error !== want.error) begin
          note_mismatch($sformatf(
            {"result mismatch: expected value=%0d position=%0d last=%0b error=%0b, ",
             "got value=%0d position=%0d last=%0b error=%0b"},
            want.value, want.position, want.last, want.error,
            seen.value, seen.position, seen.last, seen.error));
        end
      end
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w);
    start <= 1'b1;
    rand_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    shuffle_step(w);
    items_sent++;
    if (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      rand_word <= WORD_W'($urandom);
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  // Steps that emit nothing may still be in flight once the last result is out.
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= CFG_W'(data);
    @(posedge clk);
    if (idx == REG_SEQ_LENGTH) seq_len_cfg = data & 32'h3F;
    else pool_cfg = data & 32'h3F;
    reset_perm();
  endtask

  task automatic set_config(input int unsigned seq, input int unsigned pool);
    settle();
    if ($urandom_range(1)) begin
      write_reg(REG_SEQ_LENGTH, seq);
      write_reg(REG_POOL_SIZE, pool);
    end else begin
      write_reg(REG_POOL_SIZE, pool);
      write_reg(REG_SEQ_LENGTH, seq);
    end
    wr_en <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_word(31'h0000_0000);
    send_word(31'h7FFF_FFFF);
    send_word(31'h0000_0001);
    send_word(31'h2AAA_AAAA);
    send_word(31'h5555_5555);
    send_word(31'h4000_0000);
    send_word(31'h0000_0007);
    send_word(31'h7FFF_FFFE);
  endtask

  task automatic test_invalid_configs();
    set_config(0, 8);
    send_word(WORD_W'($urandom));
    set_config(5, 4);
    send_word(WORD_W'($urandom));
    set_config(1, 0);
    send_word(WORD_W'($urandom));
    set_config(1, 33);
    send_word(WORD_W'($urandom));
    set_config(63, 63);
    send_word(31'h7FFF_FFFF);
  endtask

  task automatic test_smallest_pools();
    set_config(1, 1);
    send_word(31'h7FFF_FFFF);
    set_config(2, 2);
    send_word(31'h0000_0001);
    send_word(31'h0000_0000);
  endtask

  // A register write in the middle of a shuffle drops it and starts over from identity.
  task automatic test_dropped_shuffle();
    set_config(3, 3);
    send_word(31'h0000_0002);
    send_word(31'h7FFF_FFFF);
    settle();
    write_reg(REG_SEQ_LENGTH, 3);
    wr_en <= 1'b0;
    send_word(WORD_W'($urandom));
    send_word(WORD_W'($urandom));
    send_word(WORD_W'($urandom));
  endtask

  task automatic test_random_shuffles();
    int phase;
    int first_item;
    int unsigned seq;
    int unsigned pool;
    bit broken;
    phase = 0;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      idle_enable = !(phase >= 3 && phase < 6);
      broken = 1'b0;
      if (phase == 0) begin
        seq = 32;
        pool = 32;
      end else if (phase == 1) begin
        seq = 1;
        pool = 32;
      end else if ($urandom_range(9) == 0) begin
        broken = 1'b1;
        case ($urandom_range(3))
          0: begin
            seq = 0;
            pool = $urandom_range(1, 32);
          end
          1: begin
            pool = $urandom_range(1, 31);
            seq = $urandom_range(pool + 1, 63);
          end
          2: begin
            pool = $urandom_range(33, 63);
            seq = $urandom_range(1, 63);
          end
          default: begin
            pool = 0;
            seq = $urandom_range(0, 63);
          end
        endcase
      end else begin
        pool = ($urandom_range(3) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
        seq = $urandom_range(1, pool);
      end
      set_config(seq, pool);
      if (broken) begin
        repeat ($urandom_range(1, 3)) send_word(WORD_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          repeat (pool) send_word(WORD_W'($urandom));
          if ($urandom_range(4) == 0) hold_until_drained();
        end
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(0, pool - 1)) send_word(WORD_W'($urandom));
        end
      end
      phase++;
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    reset_perm();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_invalid_configs();
    test_smallest_pools();
    test_dropped_shuffle();
    test_random_shuffles();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (draw_mismatches == 0 && pending_draws.size() == 0) begin
      $display("[partial_random_permutation_unit] OK");
    end else begin
      $display("[partial_random_permutation_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("[partial_random_permutation_unit] ERROR");
    $finish;
  end

endmodule

// File: partial_random_permutation_unit.f
src/prp_pkg.sv
src/prp_queue.sv
src/prp_front.sv
src/prp_mod.sv
src/prp_back.sv
src/partial_random_permutation_unit.sv
verif/tb_partial_random_permutation_unit.sv
